// ===== rtl/core/bmc_pkg.sv =====
// Shared types, codes and limits of the masked Benes correction block.
package bmc_pkg;

    // Default sizing of the block.
    localparam int DEF_MAX_SIZE     = 64;
    localparam int DEF_MAX_LOG      = 6;
    localparam int DEF_MAX_SWITCHES = 352;

    // Field widths of the command struct, sized for the largest legal parameters.
    localparam int CMD_EW = 10;
    localparam int CMD_SW = 14;
    localparam int CMD_DW = 4;

    // Configuration port.
    localparam int              PADDR_W       = 3;
    localparam logic [2:0]      REG_SIZE_ADDR = 3'd0;
    localparam logic [6:0]      SIZE_RESET    = 7'd64;

    // Item function codes.
    localparam logic [2:0] FUNC_LOAD_MASK = 3'd0;
    localparam logic [2:0] FUNC_LOAD_PAIR = 3'd1;
    localparam logic [2:0] FUNC_RUN       = 3'd2;
    localparam logic [2:0] FUNC_READ_CORR = 3'd3;
    localparam logic [2:0] FUNC_READ_PERM = 3'd4;

    // Datapath operation codes.
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_SW_PLACE = 3'd1;
    localparam logic [2:0] OP_SPLIT    = 3'd2;
    localparam logic [2:0] OP_MERGE    = 3'd3;
    localparam logic [2:0] OP_ODD_IN   = 3'd4;
    localparam logic [2:0] OP_ODD_OUT  = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [8:0] index;
        logic       mask_bit;
        logic       msg_zero;
        logic       msg_one;
        logic       swap_bit;
    } t_in_beat;

    typedef struct packed {
        logic       read_kind;
        logic [8:0] read_index;
        logic       bit_value;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]        op;
        logic [CMD_DW-1:0] depth;
        logic              sel;     // 1 when the frame works on the top half of its parent
        logic [CMD_EW-1:0] ea;
        logic [CMD_EW-1:0] eb;
        logic [CMD_EW-1:0] j;
        logic [CMD_SW-1:0] sw_idx;
        logic              sw_ok;
    } t_run_cmd;

endpackage

// ===== rtl/core/bmc_ctrl.sv =====
// Sequencer that walks the Benes recursion with an explicit frame stack.
module bmc_ctrl #(
    parameter int MAX_SIZE     = bmc_pkg::DEF_MAX_SIZE,
    parameter int MAX_LOG      = bmc_pkg::DEF_MAX_LOG,
    parameter int MAX_SWITCHES = bmc_pkg::DEF_MAX_SWITCHES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [6:0]        i_size,
    output logic              o_busy,
    output bmc_pkg::t_run_cmd o_cmd
);
    import bmc_pkg::*;

    localparam int NW   = $clog2(MAX_SIZE + 1);
    localparam int EW   = $clog2(MAX_SIZE);
    localparam int LW   = $clog2(MAX_LOG + 1);
    localparam int ROWS = MAX_LOG + 2;
    localparam int DW   = $clog2(ROWS);
    localparam int CW   = $clog2(2 * MAX_LOG + ROWS + 4) + 1;
    localparam int IW   = $clog2((2 * MAX_LOG + ROWS + 4) * MAX_SIZE + MAX_SWITCHES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ENTER  = 3'd1;
    localparam logic [2:0] ST_BASE3  = 3'd2;
    localparam logic [2:0] ST_IN     = 3'd3;
    localparam logic [2:0] ST_RET    = 3'd4;
    localparam logic [2:0] ST_RESUME = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [DW-1:0] r_depth, n_depth;
    logic [NW-1:0] r_i, n_i;
    logic [NW-1:0] r_n;
    logic [LW-1:0] r_log;

    logic [NW-1:0] r_fs_s   [ROWS];
    logic [EW-1:0] r_fs_pos [ROWS];
    logic          r_fs_sel [ROWS];
    logic          r_fs_ph  [ROWS];

    logic [NW-1:0]        s_cur, hs, half;
    logic [EW-1:0]        pos_cur;
    logic                 odd, more;
    logic signed [CW-1:0] col;
    logic [IW-1:0]        idx;
    logic [NW-1:0]        j;
    logic                 push, push_top;
    logic [NW-1:0]        n_clamp;
    logic [LW-1:0]        log_calc;

    assign s_cur   = r_fs_s[r_depth];
    assign pos_cur = r_fs_pos[r_depth];
    assign hs      = s_cur >> 1;
    assign odd     = s_cur[0];
    assign half    = r_n >> 1;
    assign more    = ({1'b0, r_i} + (NW+1)'(1)) < {1'b0, s_cur};
    assign j       = r_i >> 1;

    always_comb begin
        if (i_size < 7'd2) begin
            n_clamp = NW'(2);
        end else if (int'(i_size) > MAX_SIZE) begin
            n_clamp = NW'(MAX_SIZE);
        end else begin
            n_clamp = NW'(i_size);
        end
        log_calc = '0;
        for (int k = 0; k <= MAX_LOG; k++) begin
            if ((int'(1) << k) < int'(n_clamp)) begin
                log_calc = LW'(k + 1);
            end
        end
    end

    always_comb begin
        case (r_state)
            ST_ENTER: begin
                if (int'(r_log) == int'(r_depth) + 1) begin
                    col = CW'(r_depth);
                end else begin
                    col = CW'(r_depth) + CW'(1);
                end
            end
            ST_BASE3: col = CW'(r_depth) + CW'(r_i);
            ST_OUT:   col = CW'({r_log, 1'b0}) - CW'(r_depth) - CW'(2);
            default:  col = CW'(r_depth);
        endcase
        if (r_state == ST_IN || r_state == ST_OUT) begin
            idx = IW'(col[CW-2:0]) * IW'(half) + IW'(pos_cur) + IW'(j);
        end else begin
            idx = IW'(col[CW-2:0]) * IW'(half) + IW'(pos_cur);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_i      = r_i;
        push     = 1'b0;
        push_top = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = OP_NOP;
        o_cmd.depth  = CMD_DW'(r_depth);
        o_cmd.sel    = r_fs_sel[r_depth];
        o_cmd.sw_idx = CMD_SW'(idx);
        o_cmd.sw_ok  = !col[CW-1] && (idx < IW'(MAX_SWITCHES));
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_ENTER;
                    n_depth = '0;
                end
            end
            ST_ENTER: begin
                n_i = '0;
                if (s_cur < NW'(2)) begin
                    n_state = ST_RET;
                end else if (s_cur == NW'(2)) begin
                    o_cmd.op = OP_SW_PLACE;
                    o_cmd.ea = CMD_EW'(0);
                    o_cmd.eb = CMD_EW'(1);
                    n_state  = ST_RET;
                end else if (s_cur == NW'(3)) begin
                    n_state = ST_BASE3;
                end else if (int'(r_depth) + 1 >= ROWS) begin
                    n_state = ST_RET;
                end else begin
                    n_state = ST_IN;
                end
            end
            ST_BASE3: begin
                o_cmd.op = OP_SW_PLACE;
                o_cmd.ea = (r_i == NW'(1)) ? CMD_EW'(1) : CMD_EW'(0);
                o_cmd.eb = (r_i == NW'(1)) ? CMD_EW'(2) : CMD_EW'(1);
                n_i      = r_i + NW'(1);
                if (r_i == NW'(2)) begin
                    n_state = ST_RET;
                end
            end
            ST_IN: begin
                if (more) begin
                    o_cmd.op = OP_SPLIT;
                    o_cmd.ea = CMD_EW'(r_i);
                    o_cmd.eb = CMD_EW'(r_i + NW'(1));
                    o_cmd.j  = CMD_EW'(j);
                    n_i      = r_i + NW'(2);
                end else begin
                    if (odd) begin
                        o_cmd.op = OP_ODD_IN;
                        o_cmd.ea = CMD_EW'(s_cur - NW'(1));
                        o_cmd.j  = CMD_EW'(hs);
                    end
                    push     = 1'b1;
                    push_top = 1'b1;
                    n_depth  = r_depth + DW'(1);
                    n_state  = ST_ENTER;
                end
            end
            ST_RET: begin
                if (r_depth == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_depth = r_depth - DW'(1);
                    n_state = ST_RESUME;
                end
            end
            ST_RESUME: begin
                n_i = '0;
                if (!r_fs_ph[r_depth]) begin
                    push    = 1'b1;
                    n_depth = r_depth + DW'(1);
                    n_state = ST_ENTER;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (more) begin
                    o_cmd.op = OP_MERGE;
                    o_cmd.ea = CMD_EW'(r_i);
                    o_cmd.eb = CMD_EW'(r_i + NW'(1));
                    o_cmd.j  = CMD_EW'(j);
                    n_i      = r_i + NW'(2);
                end else begin
                    if (odd) begin
                        o_cmd.op = OP_ODD_OUT;
                        o_cmd.ea = CMD_EW'(s_cur - NW'(1));
                        o_cmd.j  = CMD_EW'(hs);
                    end
                    n_state = ST_RET;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_depth <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_i     <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_n         <= n_clamp;
            r_log       <= log_calc;
            r_fs_s[0]   <= n_clamp;
            r_fs_pos[0] <= '0;
            r_fs_sel[0] <= 1'b0;
        end
        if (push) begin
            r_fs_ph[r_depth]             <= !push_top;
            r_fs_sel[r_depth + DW'(1)]   <= push_top;
            if (push_top) begin
                r_fs_s[r_depth + DW'(1)]   <= hs + NW'(odd);
                r_fs_pos[r_depth + DW'(1)] <= pos_cur + EW'(s_cur >> 2);
            end else begin
                r_fs_s[r_depth + DW'(1)]   <= hs;
                r_fs_pos[r_depth + DW'(1)] <= pos_cur;
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/bmc_dp.sv =====
// Stores, scratch rows and the switch unit of the masked Benes correction block.
module bmc_dp #(
    parameter int MAX_SIZE     = bmc_pkg::DEF_MAX_SIZE,
    parameter int MAX_LOG      = bmc_pkg::DEF_MAX_LOG,
    parameter int MAX_SWITCHES = bmc_pkg::DEF_MAX_SWITCHES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  bmc_pkg::t_in_beat i_beat,
    input  bmc_pkg::t_run_cmd i_cmd,
    output logic              o_exec_busy,
    output logic              o_rd_bit
);
    import bmc_pkg::*;

    localparam int EW   = $clog2(MAX_SIZE);
    localparam int ROWS = MAX_LOG + 2;
    localparam int DW   = $clog2(ROWS);
    localparam int SWW  = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;

    logic [MAX_SIZE-1:0] r_mask;
    logic [MAX_SIZE-1:0] r_top [ROWS];
    logic [MAX_SIZE-1:0] r_bot [ROWS];
    logic [1:0]          pair_mem [MAX_SWITCHES];
    logic                corr_mem [MAX_SWITCHES];

    t_run_cmd r_cmd;
    logic [1:0] r_pair;
    logic       r_rd_kind, r_rd_ok, r_corr_rd, r_mask_rd;

    logic [DW-1:0]       d, dm1;
    logic [EW-1:0]       ea, eb, jj;
    logic [MAX_SIZE-1:0] srcv;
    logic                m0, m1, a_out, b_out, sw_op, src_we, src_two;
    logic                mask_ok, sw_ok_in;
    logic [EW-1:0]       in_eaddr;
    logic [SWW-1:0]      in_saddr;
    logic [1:0]          pair_wr;

    assign d   = r_cmd.depth[DW-1:0];
    assign dm1 = d - DW'(1);
    assign ea  = r_cmd.ea[EW-1:0];
    assign eb  = r_cmd.eb[EW-1:0];
    assign jj  = r_cmd.j[EW-1:0];

    assign in_eaddr = EW'(i_beat.index);
    assign in_saddr = SWW'(i_beat.index);
    assign mask_ok  = int'(i_beat.index) < MAX_SIZE;
    assign sw_ok_in = int'(i_beat.index) < MAX_SWITCHES;
    assign pair_wr  = i_beat.swap_bit ? {i_beat.msg_zero, i_beat.msg_one}
                                      : {i_beat.msg_one, i_beat.msg_zero};

    always_comb begin
        if (d == '0) begin
            srcv = r_mask;
        end else if (r_cmd.sel) begin
            srcv = r_top[dm1];
        end else begin
            srcv = r_bot[dm1];
        end
        if (r_cmd.op == OP_MERGE) begin
            m0 = r_bot[d][jj];
            m1 = r_top[d][jj];
        end else begin
            m0 = srcv[ea];
            m1 = srcv[eb];
        end
        sw_op = (r_cmd.op == OP_SW_PLACE) || (r_cmd.op == OP_SPLIT) || (r_cmd.op == OP_MERGE);
        if (r_cmd.sw_ok) begin
            a_out = r_pair[0] ^ m0;
            b_out = r_pair[0] ^ m1;
        end else begin
            a_out = m0;
            b_out = m1;
        end
        if (r_cmd.op == OP_ODD_OUT) begin
            a_out = r_top[d][jj];
        end
        src_we  = (r_cmd.op == OP_SW_PLACE) || (r_cmd.op == OP_MERGE) ||
                  (r_cmd.op == OP_ODD_OUT);
        src_two = (r_cmd.op != OP_ODD_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_cmd;
        end
    end

    // Element and scratch bits.
    always_ff @(posedge i_clk) begin
        if (i_take && i_beat.func == FUNC_LOAD_MASK && mask_ok) begin
            r_mask[in_eaddr] <= i_beat.mask_bit;
        end
        if (src_we) begin
            if (d == '0) begin
                r_mask[ea] <= a_out;
                if (src_two) begin
                    r_mask[eb] <= b_out;
                end
            end else if (r_cmd.sel) begin
                r_top[dm1][ea] <= a_out;
                if (src_two) begin
                    r_top[dm1][eb] <= b_out;
                end
            end else begin
                r_bot[dm1][ea] <= a_out;
                if (src_two) begin
                    r_bot[dm1][eb] <= b_out;
                end
            end
        end
        if (r_cmd.op == OP_SPLIT) begin
            r_bot[d][jj] <= a_out;
            r_top[d][jj] <= b_out;
        end
        if (r_cmd.op == OP_ODD_IN) begin
            r_top[d][jj] <= srcv[ea];
        end
        if (i_take && i_beat.func == FUNC_READ_PERM) begin
            r_mask_rd <= r_mask[in_eaddr];
        end
    end

    // Switch pair memory, read as the command enters the datapath register.
    always_ff @(posedge i_clk) begin
        if (i_take && i_beat.func == FUNC_LOAD_PAIR && sw_ok_in) begin
            pair_mem[in_saddr] <= pair_wr;
        end
        r_pair <= pair_mem[i_cmd.sw_idx[SWW-1:0]];
    end

    // Correction memory.
    always_ff @(posedge i_clk) begin
        if (sw_op && r_cmd.sw_ok) begin
            corr_mem[r_cmd.sw_idx[SWW-1:0]] <= r_pair[1] ^ r_pair[0] ^ m0 ^ m1;
        end
        if (i_take && i_beat.func == FUNC_READ_CORR) begin
            r_corr_rd <= corr_mem[in_saddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && (i_beat.func == FUNC_READ_CORR || i_beat.func == FUNC_READ_PERM)) begin
            r_rd_kind <= (i_beat.func == FUNC_READ_PERM);
            r_rd_ok   <= (i_beat.func == FUNC_READ_PERM) ? mask_ok : sw_ok_in;
        end
    end

    assign o_rd_bit    = r_rd_ok & (r_rd_kind ? r_mask_rd : r_corr_rd);
    assign o_exec_busy = (r_cmd.op != OP_NOP);

endmodule

// ===== rtl/core/benes_masked_correction.sv =====
// Load items are written at the accepting edge; a read result is registered there and
// appears in the next cycle. Throughput: one load or read beat per cycle while no run
// is in progress and no read result is held by a stalled receiver. A run occupies the
// block until the walk sequencer has issued every switch, one at a time, into the single
// switch unit and the last switch has drained from the datapath.
// Reset: synchronous active-low; clears the sequencer, the output valid and sets
// size_in_use to 64. The mask, pair and correction stores are not cleared.
module benes_masked_correction #(
    parameter int MAX_SIZE     = bmc_pkg::DEF_MAX_SIZE,
    parameter int MAX_LOG      = bmc_pkg::DEF_MAX_LOG,
    parameter int MAX_SWITCHES = bmc_pkg::DEF_MAX_SWITCHES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bmc_pkg::t_in_beat         i_in_data,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bmc_pkg::t_out_beat        o_out_data,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bmc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import bmc_pkg::*;

    logic [6:0] r_size_in_use;
    logic       take, is_read, ctrl_busy, exec_busy, rd_bit;
    logic       r_out_valid, r_out_kind;
    logic [8:0] r_out_index;
    t_run_cmd   cmd;

    // The size register is the only configuration register. Reads return it
    // zero-extended; writes take the low seven bits.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SIZE_ADDR) ? {25'd0, r_size_in_use} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_in_use <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_SIZE_ADDR) begin
            r_size_in_use <= pwdata[6:0];
        end
    end

    // A beat is refused while a run is walking the network (including the last
    // switch still in the datapath), and while a finished read beat is held by
    // a stalled receiver. A new read can enter in the same cycle the held
    // result leaves.
    assign o_in_stall = ctrl_busy || exec_busy || (r_out_valid && i_out_stall);
    assign take       = i_in_valid && !o_in_stall;
    assign is_read    = (i_in_data.func == FUNC_READ_CORR) ||
                        (i_in_data.func == FUNC_READ_PERM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_read) begin
            r_out_kind  <= (i_in_data.func == FUNC_READ_PERM);
            r_out_index <= i_in_data.index;
        end
    end

    // The read bit is captured inside the datapath at the accepting edge and
    // stays put until the next read is accepted.
    assign o_out_valid           = r_out_valid;
    assign o_out_data.read_kind  = r_out_kind;
    assign o_out_data.read_index = r_out_index;
    assign o_out_data.bit_value  = rd_bit;

    bmc_ctrl #(
        .MAX_SIZE     (MAX_SIZE),
        .MAX_LOG      (MAX_LOG),
        .MAX_SWITCHES (MAX_SWITCHES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (take && i_in_data.func == FUNC_RUN),
        .i_size  (r_size_in_use),
        .o_busy  (ctrl_busy),
        .o_cmd   (cmd)
    );

    bmc_dp #(
        .MAX_SIZE     (MAX_SIZE),
        .MAX_LOG      (MAX_LOG),
        .MAX_SWITCHES (MAX_SWITCHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_beat      (i_in_data),
        .i_cmd       (cmd),
        .o_exec_busy (exec_busy),
        .o_rd_bit    (rd_bit)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for benes_masked_correction: Benes walk predictor and read-back checks.
module tb;
    import bmc_pkg::*;

    localparam int N_MASK = 64;
    localparam int N_SW   = 352;
    // Long enough to cover the longest run at size 64, with margin.
    localparam int RUN_SETTLE = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_beat   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_beat  o_out_data;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    benes_masked_correction DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the block's state, kept in step with every accepted beat.
    bit        mask_bits [N_MASK];
    bit [1:0]  switch_pairs [N_SW];
    bit        corr_bits [N_SW];
    bit        corr_valid [N_SW];   // set once a run has produced that correction
    logic [6:0] size_reg;
    int        walk_n;
    int        walk_log;

    t_out_beat read_q[$];
    int        fail_count;
    bit        quiet;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // One switch: outputs M0^m0 and M0^m1, correction M1^M0^m0^m1.
    function automatic void apply_switch(input int idx, inout bit a, inout bit b);
        bit m0;
        bit m1;
        if (idx < 0 || idx >= N_SW) begin
            return;
        end
        m0 = a;
        m1 = b;
        corr_bits[idx]  = switch_pairs[idx][1] ^ switch_pairs[idx][0] ^ m0 ^ m1;
        corr_valid[idx] = 1'b1;
        a = switch_pairs[idx][0] ^ m0;
        b = switch_pairs[idx][0] ^ m1;
    endfunction

    // Recursive walk: input column, top half, bottom half, output column.
    function automatic void benes_walk(input int depth, input int pos, inout bit v[64],
                                       input int s);
        int  half;
        int  co;
        int  hs;
        int  col;
        bit  top[64];
        bit  bot[64];
        half = walk_n / 2;
        co   = walk_log - depth;
        if (s < 2) begin
            return;
        end
        if (s == 2) begin
            col = (co == 1) ? depth : depth + 1;
            apply_switch(col * half + pos, v[0], v[1]);
            return;
        end
        if (s == 3) begin
            apply_switch(depth * half + pos, v[0], v[1]);
            apply_switch((depth + 1) * half + pos, v[1], v[2]);
            apply_switch((depth + 2) * half + pos, v[0], v[1]);
            return;
        end
        if (depth + 1 >= 8 || s > N_MASK) begin
            return;
        end
        hs = s / 2;
        for (int i = 0; i + 1 < s; i += 2) begin
            apply_switch(depth * half + pos + i / 2, v[i], v[i + 1]);
            bot[i / 2] = v[i];
            top[i / 2] = v[i + 1];
        end
        if (s % 2 == 1) begin
            top[hs] = v[s - 1];
        end
        benes_walk(depth + 1, pos + s / 4, top, hs + s % 2);
        benes_walk(depth + 1, pos, bot, hs);
        col = depth + 2 * co - 2;
        for (int i = 0; i + 1 < s; i += 2) begin
            v[i]     = bot[i / 2];
            v[i + 1] = top[i / 2];
            apply_switch(col < 0 ? -1 : col * half + pos + i / 2, v[i], v[i + 1]);
        end
        if (s % 2 == 1) begin
            v[s - 1] = top[hs];
        end
    endfunction

    // Updates the shadow state for one accepted beat and queues any read result.
    function automatic void predict_beat(input t_in_beat b);
        t_out_beat r;
        bit        work[64];
        case (b.func)
            FUNC_LOAD_MASK: begin
                if (b.index < N_MASK) begin
                    mask_bits[b.index] = b.mask_bit;
                end
            end
            FUNC_LOAD_PAIR: begin
                if (b.index < N_SW) begin
                    switch_pairs[b.index] = b.swap_bit ? {b.msg_zero, b.msg_one}
                                                       : {b.msg_one, b.msg_zero};
                end
            end
            FUNC_RUN: begin
                walk_n = size_reg;
                if (walk_n < 2) begin
                    walk_n = 2;
                end
                if (walk_n > N_MASK) begin
                    walk_n = N_MASK;
                end
                walk_log = 0;
                while ((1 << walk_log) < walk_n) begin
                    walk_log++;
                end
                work = mask_bits;
                benes_walk(0, 0, work, walk_n);
                mask_bits = work;
            end
            FUNC_READ_CORR: begin
                r.read_kind  = 1'b0;
                r.read_index = b.index;
                r.bit_value  = (b.index < N_SW) ? corr_bits[b.index] : 1'b0;
                read_q.push_back(r);
            end
            FUNC_READ_PERM: begin
                r.read_kind  = 1'b1;
                r.read_index = b.index;
                r.bit_value  = (b.index < N_MASK) ? mask_bits[b.index] : 1'b0;
                read_q.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    // Sends one beat. Valid is left high after acceptance so that back-to-back
    // beats never see valid lowered and raised in the same time step.
    task automatic send_beat(input t_in_beat b);
        if (!quiet && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_beat(b);
    endtask

    function automatic t_in_beat make_beat(input logic [2:0] f, input int idx,
                                           input bit mb, input bit z, input bit o,
                                           input bit sw);
        t_in_beat b;
        b.func     = f;
        b.index    = idx[8:0];
        b.mask_bit = mb;
        b.msg_zero = z;
        b.msg_one  = o;
        b.swap_bit = sw;
        return b;
    endfunction

    // Drops valid and waits until every read result has come back.
    task automatic drain_reads();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (read_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes size_in_use while the block is idle; a run may still be in
    // progress with no read pending, so the full run time is allowed first.
    task automatic write_size(input logic [6:0] val);
        drain_reads();
        repeat (RUN_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_SIZE_ADDR;
        pwdata  <= {25'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        size_reg = val;
    endtask

    // A read of a correction is only aimed at an entry some run has written,
    // or beyond the store, where the block answers zero.
    function automatic int pick_corr_index();
        int idx;
        for (int k = 0; k < 20; k++) begin
            idx = $urandom_range(0, 511);
            if (idx >= N_SW || corr_valid[idx]) begin
                return idx;
            end
        end
        return N_SW + $urandom_range(0, 159);
    endfunction

    task automatic run_and_read(input int reads);
        send_beat(make_beat(FUNC_RUN, $urandom_range(0, 511), $urandom, $urandom,
                            $urandom, $urandom));
        for (int k = 0; k < reads; k++) begin
            if ($urandom_range(1)) begin
                send_beat(make_beat(FUNC_READ_CORR, pick_corr_index(), 0, 0, 0, 0));
            end else begin
                send_beat(make_beat(FUNC_READ_PERM, $urandom_range(0, walk_n - 1),
                                    0, 0, 0, 0));
            end
        end
    endtask

    // Every mask bit and every switch pair gets a value before anything reads them.
    task automatic test_fill_stores();
        for (int i = 0; i < N_MASK; i++) begin
            send_beat(make_beat(FUNC_LOAD_MASK, i, $urandom, 0, 0, 0));
        end
        for (int i = 0; i < N_SW; i++) begin
            send_beat(make_beat(FUNC_LOAD_PAIR, i, 0, $urandom, $urandom, $urandom));
        end
    endtask

    // Extremes of the fields, out-of-range indexes, unknown codes, reads before a run.
    task automatic test_directed();
        send_beat(make_beat(FUNC_LOAD_MASK, 0, 1, 1, 1, 1));
        send_beat(make_beat(FUNC_LOAD_MASK, 63, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_LOAD_MASK, 64, 1, 0, 0, 0));
        send_beat(make_beat(FUNC_LOAD_MASK, 511, 0, 1, 1, 1));
        send_beat(make_beat(FUNC_LOAD_PAIR, 0, 0, 1, 0, 1));
        send_beat(make_beat(FUNC_LOAD_PAIR, 351, 1, 0, 1, 0));
        send_beat(make_beat(FUNC_LOAD_PAIR, 352, 0, 1, 1, 1));
        send_beat(make_beat(FUNC_LOAD_PAIR, 511, 1, 1, 0, 1));
        // The permuted-bit reads below still see the loaded mask.
        send_beat(make_beat(FUNC_READ_PERM, 0, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_PERM, 63, 1, 1, 1, 1));
        send_beat(make_beat(FUNC_READ_PERM, 64, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_PERM, 511, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_CORR, 352, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_CORR, 511, 1, 1, 1, 1));
        send_beat(make_beat(3'd5, 7, 1, 1, 1, 1));
        send_beat(make_beat(3'd6, 0, 0, 0, 0, 0));
        send_beat(make_beat(3'd7, 511, 1, 0, 1, 0));
        send_beat(make_beat(FUNC_RUN, 0, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_CORR, 0, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_CORR, 351, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_PERM, 5, 0, 0, 0, 0));
        // A second run permutes the already permuted mask again.
        send_beat(make_beat(FUNC_RUN, 511, 1, 1, 1, 1));
        send_beat(make_beat(FUNC_READ_PERM, 5, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_READ_CORR, 100, 0, 0, 0, 0));
    endtask

    // Sizes with base cases, odd subnetworks and both clamps of the register.
    task automatic test_sizes();
        logic [6:0] sizes[12] = '{7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd11,
                                  7'd33, 7'd63, 7'd0, 7'd1, 7'd127};
        foreach (sizes[k]) begin
            write_size(sizes[k]);
            run_and_read(6);
        end
    endtask

    function automatic t_in_beat random_beat();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            return make_beat(FUNC_LOAD_MASK, $urandom_range(0, 80), $urandom, $urandom,
                             $urandom, $urandom);
        end else if (sel < 45) begin
            return make_beat(FUNC_LOAD_PAIR, $urandom_range(0, 511), $urandom, $urandom,
                             $urandom, $urandom);
        end else if (sel < 49) begin
            return make_beat(FUNC_RUN, $urandom_range(0, 511), $urandom, $urandom,
                             $urandom, $urandom);
        end else if (sel < 72) begin
            return make_beat(FUNC_READ_CORR, pick_corr_index(), $urandom, $urandom,
                             $urandom, $urandom);
        end else if (sel < 96) begin
            return make_beat(FUNC_READ_PERM, $urandom_range(0, 511), $urandom, $urandom,
                             $urandom, $urandom);
        end
        return make_beat(3'($urandom_range(5, 7)), $urandom_range(0, 511), $urandom,
                         $urandom, $urandom, $urandom);
    endfunction

    // Random traffic over a few sizes, with a pause for all reads midway.
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            write_size(phase == 0 ? 7'd64 : 7'($urandom_range(2, 64)));
            for (int k = 0; k < 100; k++) begin
                send_beat(random_beat());
                if (k == 50) begin
                    drain_reads();
                end
            end
        end
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        for (int k = 0; k < 60; k++) begin
            send_beat(random_beat());
        end
    endtask

    // Output stall in random bursts, with none once the tail begins.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (!quiet && $urandom_range(3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Compares each read beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (read_q.size() == 0) begin
                $error("unexpected read beat kind=%0d index=%0d", o_out_data.read_kind,
                       o_out_data.read_index);
                fail_count++;
            end else begin
                want = read_q.pop_front();
                if (o_out_data.read_kind !== want.read_kind) begin
                    $error("read_kind expected %0d actual %0d", want.read_kind,
                           o_out_data.read_kind);
                    fail_count++;
                end
                if (o_out_data.read_index !== want.read_index) begin
                    $error("read_index expected %0d actual %0d", want.read_index,
                           o_out_data.read_index);
                    fail_count++;
                end
                if (o_out_data.bit_value !== want.bit_value) begin
                    $error("bit_value expected %0d actual %0d", want.bit_value,
                           o_out_data.bit_value);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(12 * 1500000);
        $display("FAIL benes_masked_correction");
        $finish;
    end

    initial begin
        int guard;
        fail_count = 0;
        quiet      = 1'b0;
        size_reg   = SIZE_RESET;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_stores();
        test_directed();
        test_sizes();
        test_random();
        test_quiet_tail();
        i_in_valid <= 1'b0;
        guard = 0;
        while (read_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && read_q.size() == 0) begin
            $display("PASS benes_masked_correction");
        end else begin
            $display("FAIL benes_masked_correction");
        end
        $finish;
    end
endmodule
